// ===== rtl/char_lcd_nibble_writer_macros.svh =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer_macros.svh
// Assertion macros for the character LCD nibble writer RTL.
// ----------------------------------------------------------------------------
`ifndef CHAR_LCD_NIBBLE_WRITER_MACROS_SVH
`define CHAR_LCD_NIBBLE_WRITER_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked outside reset.
`define LCDNW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcdnw assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define LCDNW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcdnw assertion failed: next-cycle implication");

`else

`define LCDNW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LCDNW_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/lcdnw_pkg.sv =====
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Types and command codes for the character LCD nibble writer.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdnw_pkg;

  // Operation codes of an input request.
  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_CLEAR  = 3'd1,
    OP_HOME   = 3'd2,
    OP_CURSOR = 3'd3,
    OP_PUTC   = 3'd4
  } op_t;

  // Controller command bytes.
  localparam logic [7:0] CMD_FUNCTION_SET = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_CTRL = 8'h0F;
  localparam logic [7:0] CMD_ENTRY_MODE   = 8'h04;
  localparam logic [7:0] CMD_CLEAR        = 8'h01;
  localparam logic [7:0] CMD_HOME         = 8'h02;
  localparam logic [7:0] CMD_SET_ADDR     = 8'h80;

  // Nibble indexes within one operation (at most ten nibbles).
  localparam int unsigned NIB_IDX_W = 4;
  localparam int unsigned MAX_BYTES = 5;

  // One decoded operation: up to five bytes, sent high nibble first.
  typedef struct packed {
    logic                              has_out;
    logic                              data_first;
    logic [NIB_IDX_W-1:0]              nib_last;
    logic [MAX_BYTES-1:0][7:0]         bytes;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/lcdnw_if.sv =====
// ----------------------------------------------------------------------------
// lcdnw_if
// Valid/ready channels for operation requests and nibble writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdnw_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] operation;
  logic [7:0] char_code;
  logic       line;
  logic [7:0] column;

  modport source (output valid, output operation, output char_code,
                  output line, output column, input ready);
  modport sink   (input valid, input operation, input char_code,
                  input line, input column, output ready);
endinterface

interface lcdnw_out_if;
  logic       valid;
  logic       ready;
  logic       register_select;
  logic [3:0] nibble;
  logic       last;

  modport source (output valid, output register_select, output nibble,
                  output last, input ready);
  modport sink   (input valid, input register_select, input nibble,
                  input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/lcdnw_decode.sv =====
// ----------------------------------------------------------------------------
// lcdnw_decode
// Turns one operation request into its byte sequence and keeps the cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnw_decode #(
  parameter int unsigned LINE_LENGTH = 16
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             accept,
  input  wire logic [2:0]       operation,
  input  wire logic [7:0]       char_code,
  input  wire logic             line,
  input  wire logic [7:0]       column,
  output lcdnw_pkg::job_t       job
);

  localparam int unsigned COL_W = $clog2(LINE_LENGTH);

  logic             cur_line_r;
  logic             cur_line_nxt;
  logic [COL_W-1:0] cur_col_r;
  logic [COL_W-1:0] cur_col_nxt;

  // Column reduction table, one entry for every byte value of the column.
  logic [COL_W-1:0] mod_tbl [256];

  for (genvar g = 0; g < 256; g++) begin : g_mod
    assign mod_tbl[g] = COL_W'(g % LINE_LENGTH);
  end

  logic [COL_W-1:0] set_col;
  logic             put_line;
  logic [COL_W-1:0] put_col;
  logic [7:0]       set_byte;
  logic [7:0]       put_byte;

  assign set_col = mod_tbl[column];

  // Next position after a character, wrapping to the other line.
  always_comb begin
    if (cur_col_r == COL_W'(LINE_LENGTH - 1)) begin
      put_line = ~cur_line_r;
      put_col  = '0;
    end else begin
      put_line = cur_line_r;
      put_col  = cur_col_r + COL_W'(1);
    end
  end

  // Line 1 adds 0x40 to the address, which is bit 6.
  assign set_byte = lcdnw_pkg::CMD_SET_ADDR | {1'b0, line, 6'(set_col)};
  assign put_byte = lcdnw_pkg::CMD_SET_ADDR | {1'b0, put_line, 6'(put_col)};

  // Byte sequence and cursor update for each operation.
  always_comb begin
    job          = '0;
    cur_line_nxt = cur_line_r;
    cur_col_nxt  = cur_col_r;
    unique case (lcdnw_pkg::op_t'(operation))
      lcdnw_pkg::OP_INIT: begin
        job.has_out  = 1'b1;
        job.nib_last = lcdnw_pkg::NIB_IDX_W'(9);
        job.bytes[0] = lcdnw_pkg::CMD_FUNCTION_SET;
        job.bytes[1] = lcdnw_pkg::CMD_DISPLAY_CTRL;
        job.bytes[2] = lcdnw_pkg::CMD_ENTRY_MODE;
        job.bytes[3] = lcdnw_pkg::CMD_CLEAR;
        job.bytes[4] = lcdnw_pkg::CMD_HOME;
        cur_line_nxt = 1'b0;
        cur_col_nxt  = '0;
      end
      lcdnw_pkg::OP_CLEAR: begin
        job.has_out  = 1'b1;
        job.nib_last = lcdnw_pkg::NIB_IDX_W'(1);
        job.bytes[0] = lcdnw_pkg::CMD_CLEAR;
      end
      lcdnw_pkg::OP_HOME: begin
        job.has_out  = 1'b1;
        job.nib_last = lcdnw_pkg::NIB_IDX_W'(1);
        job.bytes[0] = lcdnw_pkg::CMD_HOME;
        cur_line_nxt = 1'b0;
        cur_col_nxt  = '0;
      end
      lcdnw_pkg::OP_CURSOR: begin
        job.has_out  = 1'b1;
        job.nib_last = lcdnw_pkg::NIB_IDX_W'(1);
        job.bytes[0] = set_byte;
        cur_line_nxt = line;
        cur_col_nxt  = set_col;
      end
      lcdnw_pkg::OP_PUTC: begin
        job.has_out    = 1'b1;
        job.data_first = 1'b1;
        job.nib_last   = lcdnw_pkg::NIB_IDX_W'(3);
        job.bytes[0]   = char_code;
        job.bytes[1]   = put_byte;
        cur_line_nxt   = put_line;
        cur_col_nxt    = put_col;
      end
      default: begin
        // Unused operation codes produce nothing.
        job.has_out = 1'b0;
      end
    endcase
  end

  // Cursor state moves only when a request is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_line_r <= 1'b0;
      cur_col_r  <= '0;
    end else if (accept) begin
      cur_line_r <= cur_line_nxt;
      cur_col_r  <= cur_col_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/char_lcd_nibble_writer.sv =====
// ----------------------------------------------------------------------------
// char_lcd_nibble_writer
// Four-bit bus front end for a two-line character LCD.
// ----------------------------------------------------------------------------
// Each request (init, clear, home, set cursor, put character) is decoded into
// its byte run when it is taken and held in a one-deep pending register; an
// emit register then sends the bytes high nibble first, one nibble write per
// cycle while the receiver is ready: 2 nibble writes for clear, home and set
// cursor, 4 for put character, 10 for init. A request passes the pending
// and then the emit register before its first nibble appears. A new request
// is taken whenever the pending register is free, which happens while the
// previous operation is still being sent, so the channel runs without gaps.
// Unused operation codes are taken and produce nothing.
`default_nettype none

`include "char_lcd_nibble_writer_macros.svh"

module char_lcd_nibble_writer #(
  parameter int unsigned LINE_LENGTH = 16
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lcdnw_in_if.sink    in_req,
  lcdnw_out_if.source out_wr
);

  lcdnw_pkg::job_t dec_job;
  lcdnw_pkg::job_t pend_r;
  lcdnw_pkg::job_t act_r;
  logic            pend_v_r;
  logic            act_v_r;
  logic [lcdnw_pkg::NIB_IDX_W-1:0] idx_r;

  logic in_fire;
  logic out_fire;
  logic act_done;
  logic load;
  logic [7:0] cur_byte;

  assign in_req.ready = ~pend_v_r;
  assign in_fire      = in_req.valid & ~pend_v_r;

  // Decoder and cursor tracking.
  lcdnw_decode #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_fire),
    .operation (in_req.operation),
    .char_code (in_req.char_code),
    .line      (in_req.line),
    .column    (in_req.column),
    .job       (dec_job)
  );

  // Handshake bookkeeping between pending and emit registers.
  assign out_fire = out_wr.valid & out_wr.ready;
  assign act_done = out_fire & out_wr.last;
  assign load     = pend_v_r & (~act_v_r | act_done);

  // Pending register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (in_fire && dec_job.has_out) begin
      pend_v_r <= 1'b1;
    end else if (load) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pend_r <= dec_job;
    end
  end

  // Emit register and nibble index.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_v_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      act_v_r <= 1'b1;
      idx_r   <= '0;
    end else if (act_done) begin
      act_v_r <= 1'b0;
    end else if (out_fire) begin
      idx_r <= idx_r + lcdnw_pkg::NIB_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      act_r <= pend_r;
    end
  end

  // Nibble selection: odd indexes carry the low half of a byte.
  assign cur_byte               = act_r.bytes[idx_r[lcdnw_pkg::NIB_IDX_W-1:1]];
  assign out_wr.valid           = act_v_r;
  assign out_wr.nibble          = idx_r[0] ? cur_byte[3:0] : cur_byte[7:4];
  assign out_wr.register_select = act_r.data_first
                                  & (idx_r[lcdnw_pkg::NIB_IDX_W-1:1] == '0);
  assign out_wr.last            = (idx_r == act_r.nib_last);

  // The nibble index never runs past the end of the operation.
  `LCDNW_ASSERT_IMP(a_idx_in_range, clk, rst_n, act_v_r, idx_r <= act_r.nib_last)

  // A pending operation is kept until the emit register takes it.
  `LCDNW_ASSERT_NXT(a_pend_kept, clk, rst_n, pend_v_r && !load, pend_v_r)

  // Every request that produces output lands in the pending register.
  `LCDNW_ASSERT_NXT(a_req_stored, clk, rst_n, in_fire && dec_job.has_out, pend_v_r)

  // A finished operation with nothing pending leaves the channel idle.
  `LCDNW_ASSERT_NXT(a_idle_after, clk, rst_n, act_done && !pend_v_r, !act_v_r)

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for the character LCD nibble writer. Operation requests are sent
// over the input channel with random gaps. A predictor keeps its own copy of
// the cursor and builds the nibble writes that each accepted request should
// produce. A checker compares every nibble write that the block hands over
// with the oldest write still outstanding.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned LINE_LEN     = 16;
  localparam logic [7:0]  LINE1_BASE   = 8'h40;
  localparam logic [2:0]  OP_SPARE_LO  = 3'd5;
  localparam logic [2:0]  OP_SPARE_HI  = 3'd7;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          LONG_HOLD    = 200;
  localparam int          RANDOM_OPS   = 315;

  // One nibble write as it appears on the result channel.
  typedef struct packed {
    logic       rs;
    logic [3:0] nibble;
    logic       last;
  } nib_write_t;

  logic clk;
  logic rst_n;

  lcdnw_in_if  req_ch ();
  lcdnw_out_if wr_ch ();

  char_lcd_nibble_writer #(
    .LINE_LENGTH(LINE_LEN)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_ch),
    .out_wr (wr_ch)
  );

  // Nibble writes still owed by the block, oldest first.
  nib_write_t  pending_writes[$];
  nib_write_t  head_write;
  // Cursor as the predictor sees it.
  logic        cur_line;
  int unsigned cur_col;
  int          fail_count;
  int          idle_cycles;
  // Idling controls for the sender and the receiver.
  bit          tx_no_idle;
  bit          rx_no_idle;
  int          rx_hold_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap length: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  // Queue one byte as two nibble writes, high nibble first.
  function automatic void push_byte(logic rs, logic [7:0] b, logic is_last);
    pending_writes.push_back('{rs, b[7:4], 1'b0});
    pending_writes.push_back('{rs, b[3:0], is_last});
  endfunction

  // Queue a set address command and move the cursor there.
  function automatic void push_address(logic ln, int unsigned col);
    push_byte(1'b0,
              lcdnw_pkg::CMD_SET_ADDR | (ln ? LINE1_BASE : 8'h00) | 8'(col),
              1'b1);
    cur_line = ln;
    cur_col  = col;
  endfunction

  // Work out the nibble writes of one accepted request.
  function automatic void predict_writes(logic [2:0] op, logic [7:0] ch, logic ln,
                                         logic [7:0] col);
    case (op)
      lcdnw_pkg::OP_INIT: begin
        push_byte(1'b0, lcdnw_pkg::CMD_FUNCTION_SET, 1'b0);
        push_byte(1'b0, lcdnw_pkg::CMD_DISPLAY_CTRL, 1'b0);
        push_byte(1'b0, lcdnw_pkg::CMD_ENTRY_MODE, 1'b0);
        push_byte(1'b0, lcdnw_pkg::CMD_CLEAR, 1'b0);
        push_byte(1'b0, lcdnw_pkg::CMD_HOME, 1'b1);
        cur_line = 1'b0;
        cur_col  = 0;
      end
      lcdnw_pkg::OP_CLEAR: begin
        push_byte(1'b0, lcdnw_pkg::CMD_CLEAR, 1'b1);
      end
      lcdnw_pkg::OP_HOME: begin
        push_byte(1'b0, lcdnw_pkg::CMD_HOME, 1'b1);
        cur_line = 1'b0;
        cur_col  = 0;
      end
      lcdnw_pkg::OP_CURSOR: begin
        push_address(ln, int'(col) % LINE_LEN);
      end
      lcdnw_pkg::OP_PUTC: begin
        push_byte(1'b1, ch, 1'b0);
        // From the last column the cursor moves to the start of the other line.
        if (cur_col >= LINE_LEN - 1) begin
          push_address(~cur_line, 0);
        end else begin
          push_address(cur_line, cur_col + 1);
        end
      end
      default: begin
      end
    endcase
  endfunction

  // Offer one request after a random gap and wait until it is taken.
  task automatic send_op(input logic [2:0] op, input logic [7:0] ch, input logic ln,
                         input logic [7:0] col);
    int gap;
    gap = tx_no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.operation <= op;
    req_ch.char_code <= ch;
    req_ch.line      <= ln;
    req_ch.column    <= col;
    do @(posedge clk); while (!req_ch.ready);
    predict_writes(op, ch, ln, col);
  endtask

  // Random request, mostly characters and cursor moves. Columns lean towards
  // the end of a line so that wrapping happens often.
  task automatic send_random_op(output bit ignored);
    int          w;
    logic [2:0]  op;
    logic [7:0]  col;
    w = $urandom_range(99);
    if (w < 6) op = lcdnw_pkg::OP_INIT;
    else if (w < 14) op = lcdnw_pkg::OP_CLEAR;
    else if (w < 22) op = lcdnw_pkg::OP_HOME;
    else if (w < 42) op = lcdnw_pkg::OP_CURSOR;
    else if (w < 92) op = lcdnw_pkg::OP_PUTC;
    else op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    if ($urandom_range(1)) col = 8'($urandom);
    else col = 8'($urandom_range(LINE_LEN - 4, LINE_LEN - 1) + 16 * $urandom_range(15));
    send_op(op, 8'($urandom), 1'($urandom), col);
    ignored = (op > lcdnw_pkg::OP_PUTC);
  endtask

  // Receiver: random stalls, a long hold-off on request.
  initial begin
    int   stall_left;
    logic rdy_next;
    stall_left = 0;
    wr_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles != 0) begin
        stall_left     = rx_hold_cycles;
        rx_hold_cycles = 0;
      end else if (stall_left == 0 && !rx_no_idle && $urandom_range(3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        rdy_next = 1'b0;
        stall_left--;
      end else begin
        rdy_next = 1'b1;
      end
      wr_ch.ready <= rdy_next;
    end
  end

  // Compare each nibble write taken from the block with the oldest one owed.
  always @(posedge clk) begin
    if (rst_n && wr_ch.valid && wr_ch.ready) begin
      if (pending_writes.size() == 0) begin
        $error("unexpected nibble write: register_select %0d nibble %h last %0d",
               wr_ch.register_select, wr_ch.nibble, wr_ch.last);
        fail_count++;
      end else begin
        head_write = pending_writes.pop_front();
        if (wr_ch.register_select !== head_write.rs) begin
          $error("register_select mismatch: expected %0d, got %0d",
                 head_write.rs, wr_ch.register_select);
          fail_count++;
        end
        if (wr_ch.nibble !== head_write.nibble) begin
          $error("nibble mismatch: expected %h, got %h", head_write.nibble, wr_ch.nibble);
          fail_count++;
        end
        if (wr_ch.last !== head_write.last) begin
          $error("last mismatch: expected %0d, got %0d", head_write.last, wr_ch.last);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: too long without any request or nibble write being taken.
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (wr_ch.valid && wr_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic test_init_sequence();
    send_op(lcdnw_pkg::OP_INIT, 8'h00, 1'b0, 8'h00);
  endtask

  task automatic test_clear_and_home();
    send_op(lcdnw_pkg::OP_CLEAR, 8'hFF, 1'b1, 8'hFF);
    send_op(lcdnw_pkg::OP_HOME, 8'hA5, 1'b1, 8'h5A);
  endtask

  // Column extremes on both lines, including reduction modulo the line length.
  task automatic test_set_cursor();
    send_op(lcdnw_pkg::OP_CURSOR, 8'hFF, 1'b0, 8'h00);
    send_op(lcdnw_pkg::OP_CURSOR, 8'h00, 1'b1, 8'hFF);
    send_op(lcdnw_pkg::OP_CURSOR, 8'h00, 1'b0, 8'(LINE_LEN - 1));
    send_op(lcdnw_pkg::OP_CURSOR, 8'h00, 1'b1, 8'(LINE_LEN));
    send_op(lcdnw_pkg::OP_CURSOR, 8'h00, 1'b0, 8'h80);
  endtask

  // Character extremes and wrapping from the last column of each line.
  task automatic test_put_character();
    send_op(lcdnw_pkg::OP_CURSOR, 8'h00, 1'b0, 8'(LINE_LEN - 2));
    send_op(lcdnw_pkg::OP_PUTC, 8'h00, 1'b1, 8'hFF);
    send_op(lcdnw_pkg::OP_PUTC, 8'hFF, 1'b0, 8'h00);
    send_op(lcdnw_pkg::OP_CURSOR, 8'h00, 1'b1, 8'(LINE_LEN - 1));
    send_op(lcdnw_pkg::OP_PUTC, 8'h5A, 1'b1, 8'h0F);
    send_op(lcdnw_pkg::OP_PUTC, 8'hA5, 1'b0, 8'hF0);
  endtask

  // Spare operation codes must produce nothing and leave the cursor alone.
  task automatic test_spare_codes();
    for (int op = OP_SPARE_LO; op <= OP_SPARE_HI; op++) begin
      send_op(3'(op), 8'($urandom), 1'($urandom), 8'($urandom));
    end
    send_op(lcdnw_pkg::OP_PUTC, 8'h41, 1'b0, 8'h00);
  endtask

  task automatic test_init_after_writes();
    send_op(lcdnw_pkg::OP_CURSOR, 8'h00, 1'b1, 8'h07);
    send_op(lcdnw_pkg::OP_INIT, 8'hFF, 1'b1, 8'hFF);
    send_op(lcdnw_pkg::OP_PUTC, 8'h7E, 1'b1, 8'h33);
  endtask

  // Both sides flat out.
  task automatic test_back_to_back();
    bit ignored;
    tx_no_idle = 1'b1;
    rx_no_idle = 1'b1;
    repeat (20) send_random_op(ignored);
    tx_no_idle = 1'b0;
    rx_no_idle = 1'b0;
  endtask

  // Receiver holds off while requests keep coming, so the block fills up.
  task automatic test_output_stall();
    bit ignored;
    tx_no_idle     = 1'b1;
    rx_hold_cycles = LONG_HOLD;
    repeat (24) send_random_op(ignored);
    tx_no_idle = 1'b0;
  endtask

  task automatic test_random_ops();
    int count;
    bit ignored;
    count = 0;
    while (count < RANDOM_OPS) begin
      send_random_op(ignored);
      if (!ignored) count++;
    end
  endtask

  initial begin
    cur_line       = 1'b0;
    cur_col        = 0;
    tx_no_idle     = 1'b0;
    rx_no_idle     = 1'b0;
    rx_hold_cycles = 0;
    rst_n            <= 1'b0;
    req_ch.valid     <= 1'b0;
    req_ch.operation <= lcdnw_pkg::OP_INIT;
    req_ch.char_code <= 8'h00;
    req_ch.line      <= 1'b0;
    req_ch.column    <= 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_init_sequence();
    test_clear_and_home();
    test_set_cursor();
    test_put_character();
    test_spare_codes();
    test_init_after_writes();
    test_back_to_back();
    test_output_stall();
    test_random_ops();

    // Let every owed write arrive, then watch for stray ones.
    req_ch.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
